FILE: hw/rtl/ssd_pkg.sv
// Shared types, codes and glyph tables for the two-digit seven-segment driver.
`default_nettype none

package ssd_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_DECIMAL = 3'd1,
    FUNC_HEX     = 3'd2,
    FUNC_BAR     = 3'd3,
    FUNC_SCAN    = 3'd4
  } ssd_func_e;

  localparam logic [7:0] PatOverL     = 8'h3F;  // "O"
  localparam logic [7:0] PatOverR     = 8'h38;  // "L"
  localparam logic [7:0] PatBarFull   = 8'h3F;  // segments A..F
  localparam logic [7:0] PatLeftRst   = 8'h00;
  localparam logic [7:0] PatRightRst  = 8'h80;  // decimal point only
  localparam logic [7:0] DecMax       = 8'd99;
  localparam logic [7:0] BarMax       = 8'd12;
  localparam logic [3:0] BarPerDigit  = 4'd6;

  typedef struct packed {
    logic [7:0] left_pattern;
    logic [7:0] right_pattern;
    logic       showing_right;
    logic       scan_on;
    logic [7:0] drive_segments;
    logic       drive_left;
    logic       drive_right;
  } ssd_state_t;

  localparam ssd_state_t StateRst = '{
    left_pattern:   PatLeftRst,
    right_pattern:  PatRightRst,
    showing_right:  1'b0,
    scan_on:        1'b0,
    drive_segments: 8'h00,
    drive_left:     1'b0,
    drive_right:    1'b0
  };

  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] g;
    case (nib)
      4'h0:    g = 8'h3F;
      4'h1:    g = 8'h06;
      4'h2:    g = 8'h5B;
      4'h3:    g = 8'h4F;
      4'h4:    g = 8'h66;
      4'h5:    g = 8'h6D;
      4'h6:    g = 8'h7D;
      4'h7:    g = 8'h27;
      4'h8:    g = 8'h7F;
      4'h9:    g = 8'h6F;
      4'hA:    g = 8'h77;
      4'hB:    g = 8'h7C;
      4'hC:    g = 8'h39;
      4'hD:    g = 8'h5E;
      4'hE:    g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

  // Lowest n segments lit, n saturates at six.
  function automatic logic [7:0] fill_mask(input logic [3:0] n);
    logic [7:0] m;
    case (n)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd3:    m = 8'h07;
      4'd4:    m = 8'h0F;
      4'd5:    m = 8'h1F;
      default: m = 8'h3F;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ssd_step.sv
// Next-state logic: applies one command or tick to the display state.
`default_nettype none

module ssd_step (
  input  wire logic [2:0]        func_i,
  input  wire logic [7:0]        value_i,
  input  wire ssd_pkg::ssd_state_t state_i,
  output ssd_pkg::ssd_state_t    state_o
);
  import ssd_pkg::*;

  logic [15:0] tens_prod;
  logic [3:0]  tens;
  logic [7:0]  tens_x10;
  logic [3:0]  units;
  logic [3:0]  bar_lvl;

  // tens = floor(v * 205 / 2048) = floor(v / 10), kept in four bits, so exact for v below 160
  assign tens_prod = {8'h00, value_i} * 16'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
  assign units     = 4'(value_i - tens_x10);
  assign bar_lvl   = (value_i > BarMax) ? BarMax[3:0] : value_i[3:0];

  always_comb begin
    state_o = state_i;
    case (ssd_func_e'(func_i))
      FUNC_TICK: begin
        if (state_i.scan_on) begin
          if (state_i.showing_right) begin
            state_o.drive_segments = state_i.left_pattern;
            state_o.drive_left     = 1'b1;
            state_o.drive_right    = 1'b0;
          end else begin
            state_o.drive_segments = state_i.right_pattern;
            state_o.drive_left     = 1'b0;
            state_o.drive_right    = 1'b1;
          end
          state_o.showing_right = ~state_i.showing_right;
        end
      end
      FUNC_DECIMAL: begin
        if (value_i > DecMax) begin
          state_o.left_pattern  = PatOverL;
          state_o.right_pattern = PatOverR;
        end else begin
          state_o.left_pattern  = glyph(tens);
          state_o.right_pattern = glyph(units);
        end
      end
      FUNC_HEX: begin
        state_o.left_pattern  = glyph(value_i[7:4]);
        state_o.right_pattern = glyph(value_i[3:0]);
      end
      FUNC_BAR: begin
        state_o.scan_on = 1'b1;
        if (bar_lvl != 4'd0) begin
          if (bar_lvl <= BarPerDigit) begin
            state_o.left_pattern  = fill_mask(bar_lvl);
            state_o.right_pattern = 8'h00;
          end else begin
            state_o.left_pattern  = PatBarFull;
            state_o.right_pattern = fill_mask(bar_lvl - BarPerDigit);
          end
        end
      end
      FUNC_SCAN: begin
        state_o.scan_on = value_i[0];
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/two_digit_seven_segment_driver.sv
// Top level of the two-digit seven-segment display driver.
`default_nettype none

// Two-digit multiplexed seven-segment driver. Each input item is a command
// (decimal, hex, bar level, scan enable) or a scan tick; every item yields
// exactly one result item holding the segment and digit-enable drive after
// that item. Items are taken one per cycle unless out_stall_i holds the
// result register: an input register feeds a single pass of glyph lookup
// and constant divide-by-ten logic that updates the display state and loads
// the result register, so the rate is set only by downstream taking it.
// Segment bits are DP,G..A, active high; after reset the first tick with
// scanning on lights the right digit, and the lit digit keeps alternating
// across scan off and on. Pattern loads show up on the next tick.
module two_digit_seven_segment_driver (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] func_i,
  input  wire logic [7:0] value_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      segments_o,
  output logic            left_on_o,
  output logic            right_on_o
);
  import ssd_pkg::*;

  logic       in_valid_q;
  logic [2:0] func_q;
  logic [7:0] value_q;
  logic       out_valid_q;
  logic [7:0] seg_q;
  logic       left_q;
  logic       right_q;
  logic       out_free;
  logic       advance;
  ssd_state_t state_q, state_d;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign advance    = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;

  ssd_step u_step (
    .func_i  (func_q),
    .value_i (value_q),
    .state_i (state_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateRst;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
    if (advance) begin
      seg_q   <= state_d.drive_segments;
      left_q  <= state_d.drive_left;
      right_q <= state_d.drive_right;
    end
  end

  assign out_valid_o = out_valid_q;
  assign segments_o  = seg_q;
  assign left_on_o   = left_q;
  assign right_on_o  = right_q;

endmodule

`default_nettype wire
